// ===== src/ppc_pkg.sv =====
package ppc_pkg;
  localparam int NATTR = 6;
  localparam int TONE = 30;
  localparam int SHADE_W = 16;
  // binary point of positions and texture coordinates
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NZ = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;      // capture input beat
    logic dot_start;    // start the dot product of the current vertex
    logic div_start;
    logic [1:0] edge_sel; // 0 (cur,prev) 1 (first,cur)
    logic interp_start;
    logic commit;       // update prev from current
    logic first_load;   // update first from current
  } ppc_cmd_t;

  typedef struct packed {
    logic dot_done;
    logic div_done;
    logic interp_done;
    logic cur_inside;
  } ppc_sts_t;

  localparam logic [1:0] EDGE_CP = 2'd0;
  localparam logic [1:0] EDGE_FC = 2'd1;

  // output source selects
  localparam logic [1:0] OSRC_CUR = 2'd0;
  localparam logic [1:0] OSRC_FIRST = 2'd1;
  localparam logic [1:0] OSRC_ISECT = 2'd2;
  localparam logic [1:0] OSRC_MARK = 2'd3;
endpackage

// ===== src/ppc_datapath.sv =====
module ppc_datapath #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic [COORD_WIDTH-1:0] in_x,
  input  logic [COORD_WIDTH-1:0] in_y,
  input  logic [COORD_WIDTH-1:0] in_z,
  input  logic [15:0] in_s,
  input  logic [COORD_WIDTH-1:0] in_u,
  input  logic [COORD_WIDTH-1:0] in_v,
  input  ppc_pkg::ppc_cmd_t cmd,
  output ppc_pkg::ppc_sts_t sts,
  input  logic [1:0] osrc,
  output logic [COORD_WIDTH-1:0] o_x,
  output logic [COORD_WIDTH-1:0] o_y,
  output logic [COORD_WIDTH-1:0] o_z,
  output logic [15:0] o_s,
  output logic [COORD_WIDTH-1:0] o_u,
  output logic [COORD_WIDTH-1:0] o_v
);
  import ppc_pkg::*;
  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + 32;      // product width
  localparam int DW = CW + 4;       // dot width (sum of three)
  localparam int TW = TONE + 1;

  logic signed [31:0] nx_r, ny_r, nz_r, off_r;
  logic signed [CW-1:0] cur_r [NATTR];
  logic signed [CW-1:0] prv_r [NATTR];
  logic signed [CW-1:0] fst_r [NATTR];
  logic signed [CW-1:0] isc_r [NATTR];
  logic signed [DW-1:0] dcur_r, dprv_r, dfst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0; ny_r <= '0; nz_r <= 32'sd1073741824; off_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NX: nx_r <= cfg_data;
        REG_NY: ny_r <= cfg_data;
        REG_NZ: nz_r <= cfg_data;
        REG_OFF: off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- dot product of the current vertex: one multiply per cycle over x,y,z ----
  logic [1:0] dk_r;
  logic dbusy_r, dfin_r;
  logic signed [DW-1:0] dacc_r;
  logic signed [CW-1:0] dop;
  logic signed [31:0] nop;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] dsum;

  always_comb begin
    case (dk_r)
      2'd0: nop = nx_r;
      2'd1: nop = ny_r;
      default: nop = nz_r;
    endcase
    dop = cur_r[{1'b0, dk_r}];
    prod = PW'(nop) * PW'(dop);
  end

  assign dsum = dacc_r + DW'(prod >>> TONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0; dfin_r <= 1'b0; dk_r <= '0;
    end else begin
      dfin_r <= 1'b0;
      if (cmd.dot_start) begin
        dbusy_r <= 1'b1; dk_r <= '0; dacc_r <= '0;
      end else if (dbusy_r) begin
        dacc_r <= dsum;
        if (dk_r == 2'd2) begin
          dbusy_r <= 1'b0; dfin_r <= 1'b1; dcur_r <= dsum;
        end else dk_r <= dk_r + 2'd1;
      end
    end
  end
  assign sts.dot_done = dfin_r;
  assign sts.cur_inside = !(dcur_r < DW'(off_r));

  // ---- edge selection: a = end at which t=0, b = other end ----
  logic signed [CW-1:0] ea [NATTR];
  logic signed [CW-1:0] eb [NATTR];
  logic signed [DW-1:0] da, db;
  logic [1:0] esel_r;
  always_comb begin
    if (esel_r == EDGE_FC) begin
      ea = fst_r; eb = cur_r; da = dfst_r; db = dcur_r;
    end else begin
      ea = cur_r; eb = prv_r; da = dcur_r; db = dprv_r;
    end
  end

  // ---- restoring divider, one quotient bit per cycle ----
  logic signed [DW:0] num, den;
  logic [DW:0] an, ad;
  logic [DW+1:0] rr_r;
  logic [DW:0] ad_r;
  logic [TW-1:0] t_r;
  logic [4:0] qn_r;
  logic vset_r, vbusy_r, vfin_r;
  logic [DW+1:0] rsh;
  always_comb begin
    num = (DW+1)'(off_r) - (DW+1)'(da);
    den = (DW+1)'(db) - (DW+1)'(da);
    an = num[DW] ? -num : num;
    ad = den[DW] ? -den : den;
    rsh = rr_r << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vset_r <= 1'b0; vbusy_r <= 1'b0; vfin_r <= 1'b0; esel_r <= EDGE_CP; qn_r <= '0;
    end else begin
      vfin_r <= 1'b0;
      if (cmd.div_start) begin
        esel_r <= cmd.edge_sel; vset_r <= 1'b1;
      end else if (vset_r) begin
        // setup cycle after edge select settles
        vset_r <= 1'b0;
        if (ad == '0) begin
          t_r <= '0; vfin_r <= 1'b1;
        end else if (an >= ad) begin
          t_r <= TW'(1) << TONE; vfin_r <= 1'b1;
        end else begin
          rr_r <= (DW+2)'(an); ad_r <= ad; t_r <= '0; qn_r <= '0; vbusy_r <= 1'b1;
        end
      end else if (vbusy_r) begin
        if (rsh >= (DW+2)'(ad_r)) begin
          rr_r <= rsh - (DW+2)'(ad_r); t_r <= {t_r[TW-2:0], 1'b1};
        end else begin
          rr_r <= rsh; t_r <= {t_r[TW-2:0], 1'b0};
        end
        if (qn_r == 5'(TONE - 1)) begin
          vbusy_r <= 1'b0; vfin_r <= 1'b1;
        end
        qn_r <= qn_r + 5'd1;
      end
    end
  end
  assign sts.div_done = vfin_r;

  // ---- interpolation: one attribute at a time, delta, multiply, add ----
  logic [2:0] ik_r;
  logic [1:0] iph_r;
  logic ibusy_r, ifin_r;
  logic signed [CW:0] dlt_r;
  logic signed [CW+TW+1:0] mp_r;
  logic signed [CW+TW+1:0] rnd;
  logic signed [CW:0] res;
  logic signed [CW:0] sat;
  always_comb begin
    rnd = (mp_r + ((CW+TW+2)'(1) <<< (TONE - 1))) >>> TONE;
    res = (CW+1)'(ea[ik_r]) + (CW+1)'(rnd);
    sat = res;
    if (ik_r == 3'd3) begin
      if (res < -(CW+1)'(32768)) sat = -(CW+1)'(32768);
      else if (res > (CW+1)'(32767)) sat = (CW+1)'(32767);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ibusy_r <= 1'b0; ifin_r <= 1'b0; ik_r <= '0; iph_r <= '0;
    end else begin
      ifin_r <= 1'b0;
      if (cmd.interp_start) begin
        ibusy_r <= 1'b1; ik_r <= '0; iph_r <= '0;
      end else if (ibusy_r) begin
        case (iph_r)
          2'd0: begin
            dlt_r <= (CW+1)'(eb[ik_r]) - (CW+1)'(ea[ik_r]);
            iph_r <= 2'd1;
          end
          2'd1: begin
            mp_r <= (CW+TW+2)'(dlt_r) * (CW+TW+2)'($signed({1'b0, t_r}));
            iph_r <= 2'd2;
          end
          default: begin
            isc_r[ik_r] <= CW'(sat);
            iph_r <= 2'd0;
            if (ik_r == 3'(NATTR - 1)) begin
              ibusy_r <= 1'b0; ifin_r <= 1'b1;
            end else ik_r <= ik_r + 3'd1;
          end
        endcase
      end
    end
  end
  assign sts.interp_done = ifin_r;

  // ---- vertex stores ----
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_r[0] <= in_x; cur_r[1] <= in_y; cur_r[2] <= in_z;
      cur_r[3] <= CW'($signed(in_s)); cur_r[4] <= in_u; cur_r[5] <= in_v;
    end
    if (cmd.commit) begin
      prv_r <= cur_r; dprv_r <= dcur_r;
    end
    if (cmd.first_load) begin
      fst_r <= cur_r; dfst_r <= dcur_r;
    end
  end

  always_comb begin
    case (osrc)
      OSRC_FIRST: begin
        o_x = fst_r[0]; o_y = fst_r[1]; o_z = fst_r[2];
        o_s = fst_r[3][15:0]; o_u = fst_r[4]; o_v = fst_r[5];
      end
      OSRC_ISECT: begin
        o_x = isc_r[0]; o_y = isc_r[1]; o_z = isc_r[2];
        o_s = isc_r[3][15:0]; o_u = isc_r[4]; o_v = isc_r[5];
      end
      OSRC_MARK: begin
        o_x = '0; o_y = '0; o_z = '0; o_s = '0; o_u = '0; o_v = '0;
      end
      default: begin
        o_x = cur_r[0]; o_y = cur_r[1]; o_z = cur_r[2];
        o_s = cur_r[3][15:0]; o_u = cur_r[4]; o_v = cur_r[5];
      end
    endcase
  end
endmodule

// ===== src/ppc_ctrl.sv =====
module ppc_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_last,
  input  logic out_free,
  input  ppc_pkg::ppc_sts_t sts,
  output ppc_pkg::ppc_cmd_t cmd,
  output logic in_rdy,
  output logic emit,
  output logic [1:0] osrc,
  output logic o_vld,
  output logic o_isect,
  output logic o_end
);
  import ppc_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_DOT = 4'd1, S_DOTW = 4'd2, S_DECIDE = 4'd3,
    S_DIV1 = 4'd4, S_INT1 = 4'd5, S_EMI1 = 4'd6, S_EMC = 4'd7, S_NEXT = 4'd8,
    S_DIV2 = 4'd9, S_INT2 = 4'd10, S_EMI2 = 4'd11, S_EMF = 4'd12, S_FIN = 4'd13;

  logic [3:0] st_r, st_nxt;
  logic inpoly_r, pin_r, fin_r, last_r;
  logic inpoly_nxt, pin_nxt, fin_nxt, last_nxt;
  logic ins;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; inpoly_r <= 1'b0; pin_r <= 1'b0; fin_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      st_r <= st_nxt; inpoly_r <= inpoly_nxt; pin_r <= pin_nxt; fin_r <= fin_nxt;
      last_r <= last_nxt;
    end
  end

  assign ins = sts.cur_inside;

  always_comb begin
    st_nxt = st_r; inpoly_nxt = inpoly_r; pin_nxt = pin_r; fin_nxt = fin_r;
    last_nxt = last_r;
    cmd = '0; in_rdy = 1'b0; emit = 1'b0; osrc = OSRC_CUR;
    o_vld = 1'b1; o_isect = 1'b0; o_end = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load_in = 1'b1; last_nxt = in_last; st_nxt = S_DOT;
        end
      end
      S_DOT: begin
        cmd.dot_start = 1'b1; st_nxt = S_DOTW;
      end
      S_DOTW: if (sts.dot_done) st_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!inpoly_r) begin
          // first vertex; a lone final vertex leaves the polygon closed
          cmd.first_load = 1'b1; cmd.commit = 1'b1;
          fin_nxt = ins; pin_nxt = ins; inpoly_nxt = !last_r;
          if (!last_r) st_nxt = S_IDLE;
          else if (ins) st_nxt = S_EMC;
          else st_nxt = S_FIN;
        end else if (pin_r != ins) begin
          cmd.div_start = 1'b1; cmd.edge_sel = EDGE_CP; st_nxt = S_DIV1;
        end else st_nxt = S_EMC;
      end
      S_DIV1: if (sts.div_done) begin
        cmd.interp_start = 1'b1; st_nxt = S_INT1;
      end
      S_INT1: if (sts.interp_done) st_nxt = S_EMI1;
      S_EMI1: begin
        // last beat when nothing follows on the closing edge
        osrc = OSRC_ISECT; o_isect = 1'b1;
        o_end = last_r && !ins && !fin_r;
        if (out_free) begin
          emit = 1'b1;
          if (o_end) begin
            inpoly_nxt = 1'b0; st_nxt = S_IDLE;
          end else st_nxt = S_EMC;
        end
      end
      S_EMC: begin
        if (ins) begin
          o_end = !inpoly_r;
          if (out_free) begin
            emit = 1'b1; st_nxt = inpoly_r ? S_NEXT : S_IDLE;
          end
        end else st_nxt = S_NEXT;
      end
      S_NEXT: begin
        // after current vertex: handle closing edge or commit
        if (!last_r) begin
          cmd.commit = 1'b1; pin_nxt = ins; st_nxt = S_IDLE;
        end else if (ins != fin_r) begin
          cmd.div_start = 1'b1; cmd.edge_sel = EDGE_FC; st_nxt = S_DIV2;
        end else if (fin_r) st_nxt = S_EMF;
        else st_nxt = S_FIN;
      end
      S_DIV2: if (sts.div_done) begin
        cmd.interp_start = 1'b1; st_nxt = S_INT2;
      end
      S_INT2: if (sts.interp_done) st_nxt = S_EMI2;
      S_EMI2: begin
        osrc = OSRC_ISECT; o_isect = 1'b1; o_end = !fin_r;
        if (out_free) begin
          emit = 1'b1;
          if (fin_r) st_nxt = S_EMF;
          else begin
            inpoly_nxt = 1'b0; st_nxt = S_IDLE;
          end
        end
      end
      S_EMF: begin
        osrc = OSRC_FIRST; o_end = 1'b1;
        if (out_free) begin
          emit = 1'b1; inpoly_nxt = 1'b0; st_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        // final step gave nothing: marker beat
        osrc = OSRC_MARK; o_vld = 1'b0; o_end = 1'b1;
        if (out_free) begin
          emit = 1'b1; inpoly_nxt = 1'b0; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== src/polygon_plane_clipper.sv =====
// single-plane polygon clipper: vertices stream in one beat at a time and are
// clipped against the plane n.p >= offset; the first vertex is held and the
// closing edge is handled on the final beat, so output is a rotation of the
// classic order. one input beat is taken only when the previous one is fully
// done. a vertex without a crossing is accepted, gets its dot product on one
// shared multiplier over x, y and z, and is decided, emitted and committed;
// each crossing adds a setup step and 30 quotient bits of the restoring
// divider, then delta, multiply and add per attribute on its own multiplier.
// a final beat can carry two crossings. a result waits in the output
// register while out_ready is low, and the controller stalls behind it. a
// polygon whose final beat yields nothing ends in a marker beat with
// vertex_valid low, polygon_end high and all other fields zero.
module polygon_plane_clipper #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic [COORD_WIDTH-1:0] in_pos_x,
  input  logic [COORD_WIDTH-1:0] in_pos_y,
  input  logic [COORD_WIDTH-1:0] in_pos_z,
  input  logic [15:0] in_shade,
  input  logic [COORD_WIDTH-1:0] in_tex_u,
  input  logic [COORD_WIDTH-1:0] in_tex_v,
  input  logic in_final_vertex,
  output logic out_valid,
  input  logic out_ready,
  output logic out_vertex_valid,
  output logic [COORD_WIDTH-1:0] out_out_x,
  output logic [COORD_WIDTH-1:0] out_out_y,
  output logic [COORD_WIDTH-1:0] out_out_z,
  output logic [15:0] out_out_shade,
  output logic [COORD_WIDTH-1:0] out_out_u,
  output logic [COORD_WIDTH-1:0] out_out_v,
  output logic out_is_intersection,
  output logic out_polygon_end
);
  import ppc_pkg::*;

  ppc_cmd_t cmd;
  ppc_sts_t sts;
  logic in_rdy, emit, o_vld, o_isect, o_end;
  logic [1:0] osrc;
  logic [COORD_WIDTH-1:0] dx, dy, dz, du, dv;
  logic [15:0] ds;

  // output register: one beat held until taken
  logic ov_r;
  assign in_ready = in_rdy;

  ppc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_valid && in_ready), .in_last(in_final_vertex),
    .out_free(!ov_r || out_ready), .sts, .cmd, .in_rdy, .emit,
    .osrc, .o_vld, .o_isect, .o_end
  );

  ppc_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx(cfg_index), .cfg_data(cfg_wdata),
    .in_x(in_pos_x), .in_y(in_pos_y), .in_z(in_pos_z), .in_s(in_shade),
    .in_u(in_tex_u), .in_v(in_tex_v), .cmd, .sts,
    .osrc,
    .o_x(dx), .o_y(dy), .o_z(dz), .o_s(ds), .o_u(du), .o_v(dv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (emit) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_vertex_valid <= o_vld;
      out_out_x <= dx; out_out_y <= dy; out_out_z <= dz;
      out_out_shade <= ds; out_out_u <= du; out_out_v <= dv;
      out_is_intersection <= o_isect;
      out_polygon_end <= o_end;
    end
  end
  assign out_valid = ov_r;
endmodule

// ===== test/tb.sv =====
module tb;
  import ppc_pkg::*;

  localparam int CW = 32;
  localparam longint ONE30 = 64'sd1 << 30;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [CW-1:0] in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v;
  logic [15:0] in_shade;
  logic in_final_vertex;
  logic out_valid;
  logic out_ready;
  logic out_vertex_valid;
  logic [CW-1:0] out_out_x, out_out_y, out_out_z, out_out_u, out_out_v;
  logic [15:0] out_out_shade;
  logic out_is_intersection;
  logic out_polygon_end;

  // one vertex beat as offered to the block
  typedef struct packed {
    logic [CW-1:0] px, py, pz;
    logic [15:0] sh;
    logic [CW-1:0] tu, tv;
    logic fin;
  } vert_t;

  // one result beat
  typedef struct packed {
    logic vv;
    logic [CW-1:0] x, y, z;
    logic [15:0] sh;
    logic [CW-1:0] u, v;
    logic isect;
    logic pend;
  } clip_out_t;

  polygon_plane_clipper #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_shade(in_shade), .in_tex_u(in_tex_u), .in_tex_v(in_tex_v),
    .in_final_vertex(in_final_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_vertex_valid(out_vertex_valid),
    .out_out_x(out_out_x), .out_out_y(out_out_y), .out_out_z(out_out_z),
    .out_out_shade(out_out_shade), .out_out_u(out_out_u), .out_out_v(out_out_v),
    .out_is_intersection(out_is_intersection), .out_polygon_end(out_polygon_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // plane and clip state mirrored on the test side
  longint plane_n [3];
  longint plane_d;
  longint first_attr [6];
  longint prev_attr [6];
  bit first_in, prev_in, open_poly;

  vert_t pending_verts [$];
  clip_out_t clipped_verts [$];
  int errors;
  int shown;
  longint cycles;
  bit in_idle_on, out_idle_on;
  int hold_cycles;
  bit hold_req;
  bit hold_done;

  function automatic longint plane_dot(longint a [6]);
    longint s;
    s = 0;
    for (int k = 0; k < 3; k++) s += (plane_n[k] * a[k]) >>> 30;
    return s;
  endfunction

  function automatic clip_out_t make_vert(longint a [6], bit isect);
    clip_out_t o;
    o = '0;
    o.vv = 1'b1;
    o.x = a[0][CW-1:0];
    o.y = a[1][CW-1:0];
    o.z = a[2][CW-1:0];
    o.sh = a[3][15:0];
    o.u = a[4][CW-1:0];
    o.v = a[5][CW-1:0];
    o.isect = isect;
    return o;
  endfunction

  // intersection on edge (cur, prv) with interpolation from cur
  function automatic clip_out_t edge_point(longint cur [6], longint prv [6],
                                           longint dc, longint dp);
    longint an, ad, t, r, d, v;
    longint res [6];
    an = plane_d - dc;
    if (an < 0) an = -an;
    ad = dp - dc;
    if (ad < 0) ad = -ad;
    t = 0;
    if (ad == 0) t = 0;
    else if (an >= ad) t = ONE30;
    else begin
      r = an;
      for (int i = 0; i < 30; i++) begin
        r = r <<< 1;
        t = t <<< 1;
        if (r >= ad) begin
          r -= ad;
          t |= 1;
        end
      end
    end
    for (int k = 0; k < 6; k++) begin
      d = prv[k] - cur[k];
      v = cur[k] + ((d * t + (64'sd1 <<< 29)) >>> 30);
      if (k == 3) begin
        if (v < -32768) v = -32768;
        else if (v > 32767) v = 32767;
      end
      res[k] = v;
    end
    return make_vert(res, 1'b1);
  endfunction

  // run one accepted vertex through the clip rules, queue its results
  task automatic clip_vertex(vert_t it);
    longint a [6];
    longint dc;
    bit is_in;
    clip_out_t outs [$];
    a[0] = longint'($signed(it.px));
    a[1] = longint'($signed(it.py));
    a[2] = longint'($signed(it.pz));
    a[3] = longint'($signed(it.sh));
    a[4] = longint'($signed(it.tu));
    a[5] = longint'($signed(it.tv));
    dc = plane_dot(a);
    is_in = !(dc < plane_d);
    if (!open_poly) begin
      first_attr = a;
      prev_attr = a;
      first_in = is_in;
      prev_in = is_in;
      open_poly = 1'b1;
      if (it.fin && is_in) outs.push_back(make_vert(a, 1'b0));
    end else begin
      if (prev_in != is_in)
        outs.push_back(edge_point(a, prev_attr, dc, plane_dot(prev_attr)));
      if (is_in) outs.push_back(make_vert(a, 1'b0));
      if (it.fin) begin
        if (is_in != first_in)
          outs.push_back(edge_point(first_attr, a, plane_dot(first_attr), dc));
        if (first_in) outs.push_back(make_vert(first_attr, 1'b0));
      end else begin
        prev_attr = a;
        prev_in = is_in;
      end
    end
    if (it.fin) begin
      // fully clipped or empty closing: marker beat
      if (outs.size() == 0) outs.push_back('0);
      outs[outs.size()-1].pend = 1'b1;
      open_poly = 1'b0;
    end
    foreach (outs[i]) clipped_verts.push_back(outs[i]);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        clip_vertex({in_pos_x, in_pos_y, in_pos_z, in_shade, in_tex_u, in_tex_v,
                     in_final_vertex});
      end
      if (!in_valid || in_ready) begin
        if (pending_verts.size() > 0 && !(in_idle_on && $urandom_range(99) < 38)) begin
          vert_t it;
          it = pending_verts.pop_front();
          in_valid <= 1'b1;
          {in_pos_x, in_pos_y, in_pos_z, in_shade, in_tex_u, in_tex_v,
           in_final_vertex} <= it;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin
    clip_out_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_vertex_valid, out_out_x, out_out_y, out_out_z, out_out_shade,
               out_out_u, out_out_v, out_is_intersection, out_polygon_end};
        if (clipped_verts.size() == 0) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("unexpected beat %h", got);
          end
        end else begin
          want = clipped_verts.pop_front();
          if (got !== want) begin
            errors++;
            if (shown < 10) begin
              shown++;
              $display("mismatch exp vv=%0b x=%h y=%h z=%h sh=%h u=%h v=%h is=%0b pe=%0b",
                       want.vv, want.x, want.y, want.z, want.sh, want.u, want.v,
                       want.isect, want.pend);
              $display("         got vv=%0b x=%h y=%h z=%h sh=%h u=%h v=%h is=%0b pe=%0b",
                       got.vv, got.x, got.y, got.z, got.sh, got.u, got.v,
                       got.isect, got.pend);
            end
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_req && !hold_done && hold_cycles == 0) begin
        hold_cycles <= 3000;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= (hold_cycles == 1);
      end else begin
        out_ready <= !(out_idle_on && $urandom_range(99) < 38);
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2_000_000) begin
      $display("polygon_plane_clipper test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NX: plane_n[0] = longint'($signed(val));
      REG_NY: plane_n[1] = longint'($signed(val));
      REG_NZ: plane_n[2] = longint'($signed(val));
      default: plane_d = longint'($signed(val));
    endcase
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] off);
    write_reg(REG_NX, nx);
    write_reg(REG_NY, ny);
    write_reg(REG_NZ, nz);
    write_reg(REG_OFF, off);
  endtask

  // wait until every queued vertex is in and every result out, then settle
  task automatic drain();
    while (pending_verts.size() > 0 || in_valid || clipped_verts.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic vert_t rand_vert(bit fin);
    vert_t it;
    it.px = rand_coord();
    it.py = rand_coord();
    it.pz = rand_coord();
    it.sh = $urandom;
    it.tu = $urandom;
    it.tv = $urandom;
    it.fin = fin;
    return it;
  endfunction

  function automatic vert_t mk(int x, int y, int z, logic [15:0] sh, bit fin);
    vert_t it;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.sh = sh;
    it.tu = $urandom;
    it.tv = $urandom;
    it.fin = fin;
    return it;
  endfunction

  task automatic push_polygon(int n);
    for (int i = 0; i < n; i++) pending_verts.push_back(rand_vert(i == n - 1));
  endtask

  initial begin
    errors = 0;
    shown = 0;
    cycles = 0;
    hold_req = 0;
    in_idle_on = 1;
    out_idle_on = 1;
    open_poly = 0;
    first_in = 0;
    prev_in = 0;
    plane_n[0] = 0;
    plane_n[1] = 0;
    plane_n[2] = ONE30;
    plane_d = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_shade = '0;
    in_tex_u = '0;
    in_tex_v = '0;
    in_final_vertex = 1'b0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset plane z >= 0
    pending_verts.push_back(mk(5 << 16, 0, 3 << 16, 16'h7fff, 1));   // single inside
    pending_verts.push_back(mk(0, 0, -(1 << 16), 16'h8000, 1));      // single outside
    pending_verts.push_back(mk(0, 0, -(1 << 16), 16'h0000, 0));      // all outside
    pending_verts.push_back(mk(1, 0, -(2 << 16), 16'h1234, 1));
    pending_verts.push_back(mk(0, 0, 1 << 16, 16'h8000, 0));         // triangle crossing
    pending_verts.push_back(mk(4 << 16, 0, -(1 << 16), 16'h7fff, 0));
    pending_verts.push_back(mk(0, 4 << 16, 2 << 16, 16'h4000, 1));
    pending_verts.push_back(mk(0, 0, -(3 << 16), 16'h7fff, 0));      // first outside
    pending_verts.push_back(mk(0, 0, 1 << 16, 16'h8000, 0));
    pending_verts.push_back(mk(0, 0, 0, 16'h0001, 1));               // on the plane
    pending_verts.push_back({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h7fff,
                             32'h7fff_ffff, 32'h8000_0000, 1'b0});
    pending_verts.push_back({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'h8000,
                             32'h8000_0000, 32'h7fff_ffff, 1'b1});
    drain();

    // extreme normals and offsets
    set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000, 32'h7fff_ffff);
    push_polygon(3);
    push_polygon(4);
    drain();
    set_plane(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    push_polygon(3);
    push_polygon(5);
    drain();

    // random phases with varied planes
    for (int ph = 0; ph < 6; ph++) begin
      int made;
      set_plane($urandom_range(0, 1 << 31) - (1 << 30), $urandom, $urandom,
                (ph % 2) ? $urandom : 32'($signed($urandom_range(0, 10 << 16)) - (5 << 16)));
      in_idle_on = (ph != 2);
      out_idle_on = (ph != 2);
      if (ph == 4) hold_req = 1;
      made = 0;
      while (made < 65) begin
        int n;
        n = ($urandom_range(9) == 0) ? 1 : $urandom_range(3, 7);
        push_polygon(n);
        made += n;
      end
      drain();
      hold_req = 0;
    end

    while (hold_cycles != 0) @(posedge clk);
    drain();
    if (errors == 0) begin
      $display("polygon_plane_clipper test passed");
    end else begin
      $display("polygon_plane_clipper test failed");
    end
    $finish;
  end
endmodule

// ===== polygon_plane_clipper.f =====
src/ppc_pkg.sv
src/ppc_datapath.sv
src/ppc_ctrl.sv
src/polygon_plane_clipper.sv
test/tb.sv
